### rtl/stbst_pkg.sv
package stbst_pkg;

  localparam int DEPTH_DEF = 32;
  localparam int VAL_W     = 32;
  localparam int POS_W     = 11;

  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_SEARCH  = 1'b1;
  localparam logic KIND_SORT   = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_P_RD_LO,
    ST_P_RD_HI,
    ST_P_WR_LO,
    ST_P_WR_HI,
    ST_P_SCAN,
    ST_P_CMP,
    ST_P_SWP_A,
    ST_P_SWP_B,
    ST_P_FIN_A,
    ST_P_FIN_B,
    ST_P_NEXT,
    ST_P_POP,
    ST_Q_PROBE,
    ST_Q_CMP,
    ST_RESULT
  } state_t;

  // request from the channel side into the sequencer
  typedef struct packed {
    logic                    go;
    logic                    action;
    logic                    last;
    logic signed [VAL_W-1:0] value;
  } req_t;

  // finished result from the sequencer
  typedef struct packed {
    logic             valid;
    logic             kind;
    logic             found;
    logic [POS_W-1:0] position;
  } rsp_t;

endpackage

### rtl/stbst_if.sv
interface stbst_in_if;
  logic                               valid;
  logic                               ready;
  logic                               action;
  logic signed [stbst_pkg::VAL_W-1:0] value;
  logic                               last;

  modport source (output valid, output action, output value, output last, input ready);
  modport sink   (input valid, input action, input value, input last, output ready);
endinterface

interface stbst_out_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic                         found;
  logic [stbst_pkg::POS_W-1:0]  position;

  modport source (output valid, output kind, output found, output position, input ready);
  modport sink   (input valid, input kind, input found, input position, output ready);
endinterface

### rtl/sort_then_binary_search_table.sv
// Load / sort / search table of signed 32-bit values.
// in_ch (valid/ready): action 0 loads value into the next free entry; a load
//   with last set sorts the loaded entries ascending (quicksort, first
//   element as pivot, Lomuto partition). action 1 binary searches value.
//   A load after a finished sort starts a new set; loads past DEPTH are
//   dropped but a last still triggers the sort.
// out_ch (valid/ready): kind 0 = sort done; kind 1 = search answer with
//   found and 1-based position (0 when not found).
// Flow: a plain load gives no result. A search takes a read state and a
//   compare state per probe. The sort is set by the one store RAM (one read
//   and one write port) and the one shared comparator: each partition has
//   setup states that move the pivot to the end, then a read and a compare
//   per scanned element, a two-step write per swap, a final pivot swap
//   unless the pivot already sits in place, then wrap-up; a stack pop starts
//   a parked range. in_ch.ready is low while an item is worked on.
// Results pass through a one-deep output register: the next item is taken
//   while a result waits, and a new result holds in the sequencer until the
//   register frees. Reset clears count and sorted flag; the store itself is
//   not cleared and needs no clearing pass.
module sort_then_binary_search_table #(
  parameter int DEPTH = stbst_pkg::DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  stbst_in_if.sink        in_ch,
  stbst_out_if.source     out_ch
);

  stbst_pkg::req_t req;
  stbst_pkg::rsp_t rsp;
  logic            core_idle;
  logic            slot_free;

  logic                         out_valid_r, out_valid_nxt;
  logic                         out_kind_r, out_found_r;
  logic [stbst_pkg::POS_W-1:0]  out_pos_r;

  assign in_ch.ready = core_idle;

  always_comb begin
    req        = '0;
    req.go     = in_ch.valid && core_idle;
    req.action = in_ch.action;
    req.last   = in_ch.last;
    req.value  = in_ch.value;
  end

  // output register frees when empty or being drained this cycle
  assign slot_free = !out_valid_r || out_ch.ready;

  stbst_core #(.DEPTH(DEPTH)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .idle      (core_idle),
    .slot_free (slot_free),
    .rsp       (rsp)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (rsp.valid && slot_free) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp.valid && slot_free) begin
      out_kind_r  <= rsp.kind;
      out_found_r <= rsp.found;
      out_pos_r   <= rsp.position;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.kind     = out_kind_r;
  assign out_ch.found    = out_found_r;
  assign out_ch.position = out_pos_r;

endmodule

### rtl/stbst_ram.sv
module stbst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/stbst_core.sv
module stbst_core #(
  parameter int DEPTH = stbst_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  stbst_pkg::req_t   req,
  output logic              idle,
  input  logic              slot_free,
  output stbst_pkg::rsp_t   rsp
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int W1    = IDX_W + 1;
  localparam int VAL_W = stbst_pkg::VAL_W;
  localparam int POS_W = stbst_pkg::POS_W;

  stbst_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             sorted_r, sorted_nxt;
  logic [CNT_W-1:0] sp_r, sp_nxt;
  logic [IDX_W-1:0] lo_r, lo_nxt, hi_r, hi_nxt, i_r, i_nxt, st_r, st_nxt;
  logic [VAL_W-1:0] piv_r, piv_nxt, tmp_r, tmp_nxt;
  logic [CNT_W-1:0] left_r, left_nxt, rp1_r, rp1_nxt;
  logic             kind_r, kind_nxt, found_r, found_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;

  // store and range stack ports
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  logic [VAL_W-1:0] mem_wdata, mem_rdata;
  logic             stk_we;
  logic [IDX_W-1:0] stk_waddr, stk_raddr;
  logic [2*IDX_W-1:0] stk_wdata, stk_rdata;

  // shared compare unit: read data against pivot or search key
  logic cmp_lt, cmp_eq;
  assign cmp_lt = $signed(mem_rdata) < $signed(piv_r);
  assign cmp_eq = mem_rdata == piv_r;

  // load bookkeeping
  logic [CNT_W-1:0] eff_cnt, ld_cnt;
  logic             ld_room;
  assign eff_cnt = sorted_r ? '0 : cnt_r;
  assign ld_room = eff_cnt < CNT_W'(DEPTH);
  assign ld_cnt  = ld_room ? eff_cnt + CNT_W'(1) : eff_cnt;

  // probe midpoint and partition split tests
  logic [CNT_W:0]   mid_sum;
  logic [IDX_W-1:0] mid;
  logic             probe_ok;
  logic             lft_ok, rgt_ok;
  logic [IDX_W-1:0] st_m1, st_p1;
  assign probe_ok = left_r < rp1_r;
  assign mid_sum  = {1'b0, left_r} + {1'b0, rp1_r} - (CNT_W+1)'(1);
  assign mid      = mid_sum[IDX_W:1];
  assign lft_ok   = {1'b0, st_r} > ({1'b0, lo_r} + W1'(1));
  assign rgt_ok   = {1'b0, hi_r} > ({1'b0, st_r} + W1'(1));
  assign st_m1    = st_r - IDX_W'(1);
  assign st_p1    = st_r + IDX_W'(1);

  stbst_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  stbst_ram #(.WIDTH(2*IDX_W), .DEPTH(DEPTH)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      stbst_pkg::ST_IDLE: begin
        if (req.go) begin
          if (req.action == stbst_pkg::ACT_SEARCH) begin
            state_nxt = stbst_pkg::ST_Q_PROBE;
          end else if (req.last) begin
            state_nxt = (ld_cnt >= CNT_W'(2)) ? stbst_pkg::ST_P_RD_LO : stbst_pkg::ST_RESULT;
          end
        end
      end
      stbst_pkg::ST_P_RD_LO: state_nxt = stbst_pkg::ST_P_RD_HI;
      stbst_pkg::ST_P_RD_HI: state_nxt = stbst_pkg::ST_P_WR_LO;
      stbst_pkg::ST_P_WR_LO: state_nxt = stbst_pkg::ST_P_WR_HI;
      stbst_pkg::ST_P_WR_HI: state_nxt = stbst_pkg::ST_P_SCAN;
      stbst_pkg::ST_P_SCAN: begin
        if (i_r != hi_r) begin
          state_nxt = stbst_pkg::ST_P_CMP;
        end else begin
          state_nxt = (st_r == hi_r) ? stbst_pkg::ST_P_NEXT : stbst_pkg::ST_P_FIN_A;
        end
      end
      stbst_pkg::ST_P_CMP: begin
        state_nxt = (cmp_lt && st_r != i_r) ? stbst_pkg::ST_P_SWP_A : stbst_pkg::ST_P_SCAN;
      end
      stbst_pkg::ST_P_SWP_A: state_nxt = stbst_pkg::ST_P_SWP_B;
      stbst_pkg::ST_P_SWP_B: state_nxt = stbst_pkg::ST_P_SCAN;
      stbst_pkg::ST_P_FIN_A: state_nxt = stbst_pkg::ST_P_FIN_B;
      stbst_pkg::ST_P_FIN_B: state_nxt = stbst_pkg::ST_P_NEXT;
      stbst_pkg::ST_P_NEXT: begin
        if (lft_ok || rgt_ok) begin
          state_nxt = stbst_pkg::ST_P_RD_LO;
        end else begin
          state_nxt = (sp_r == '0) ? stbst_pkg::ST_RESULT : stbst_pkg::ST_P_POP;
        end
      end
      stbst_pkg::ST_P_POP: state_nxt = stbst_pkg::ST_P_RD_LO;
      stbst_pkg::ST_Q_PROBE: begin
        state_nxt = probe_ok ? stbst_pkg::ST_Q_CMP : stbst_pkg::ST_RESULT;
      end
      stbst_pkg::ST_Q_CMP: begin
        state_nxt = (cmp_eq || probe_ok == 1'b0) ? stbst_pkg::ST_RESULT
                                                 : stbst_pkg::ST_Q_PROBE;
      end
      stbst_pkg::ST_RESULT: begin
        if (slot_free) begin
          state_nxt = stbst_pkg::ST_IDLE;
        end
      end
      default: state_nxt = stbst_pkg::ST_IDLE;
    endcase
  end

  // memory controls and handshake outputs
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = '0;
    stk_we    = 1'b0;
    stk_waddr = sp_r[IDX_W-1:0];
    stk_wdata = {st_p1, hi_r};
    stk_raddr = '0;
    idle      = 1'b0;
    rsp       = '0;
    unique case (state_r)
      stbst_pkg::ST_IDLE: begin
        idle = 1'b1;
        if (req.go && req.action == stbst_pkg::ACT_LOAD && ld_room) begin
          mem_we    = 1'b1;
          mem_waddr = eff_cnt[IDX_W-1:0];
          mem_wdata = req.value;
        end
      end
      stbst_pkg::ST_P_RD_LO: mem_raddr = lo_r;
      stbst_pkg::ST_P_RD_HI: mem_raddr = hi_r;
      stbst_pkg::ST_P_WR_LO: begin
        mem_we    = 1'b1;
        mem_waddr = lo_r;
        mem_wdata = mem_rdata;
      end
      stbst_pkg::ST_P_WR_HI: begin
        mem_we    = 1'b1;
        mem_waddr = hi_r;
        mem_wdata = piv_r;
      end
      stbst_pkg::ST_P_SCAN: mem_raddr = (i_r != hi_r) ? i_r : st_r;
      stbst_pkg::ST_P_CMP: mem_raddr = st_r;
      stbst_pkg::ST_P_SWP_A: begin
        mem_we    = 1'b1;
        mem_waddr = i_r;
        mem_wdata = mem_rdata;
      end
      stbst_pkg::ST_P_SWP_B: begin
        mem_we    = 1'b1;
        mem_waddr = st_r;
        mem_wdata = tmp_r;
      end
      stbst_pkg::ST_P_FIN_A: begin
        mem_we    = 1'b1;
        mem_waddr = hi_r;
        mem_wdata = mem_rdata;
      end
      stbst_pkg::ST_P_FIN_B: begin
        mem_we    = 1'b1;
        mem_waddr = st_r;
        mem_wdata = piv_r;
      end
      stbst_pkg::ST_P_NEXT: begin
        stk_we    = lft_ok && rgt_ok;
        stk_raddr = sp_r[IDX_W-1:0] - IDX_W'(1);
      end
      stbst_pkg::ST_P_POP: ;
      stbst_pkg::ST_Q_PROBE: mem_raddr = mid;
      stbst_pkg::ST_Q_CMP: ;
      stbst_pkg::ST_RESULT: begin
        rsp.valid    = 1'b1;
        rsp.kind     = kind_r;
        rsp.found    = found_r;
        rsp.position = pos_r;
      end
      default: ;
    endcase
  end

  // datapath registers
  always_comb begin
    cnt_nxt    = cnt_r;
    sorted_nxt = sorted_r;
    sp_nxt     = sp_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    i_nxt      = i_r;
    st_nxt     = st_r;
    piv_nxt    = piv_r;
    tmp_nxt    = tmp_r;
    left_nxt   = left_r;
    rp1_nxt    = rp1_r;
    kind_nxt   = kind_r;
    found_nxt  = found_r;
    pos_nxt    = pos_r;
    unique case (state_r)
      stbst_pkg::ST_IDLE: begin
        if (req.go) begin
          if (req.action == stbst_pkg::ACT_LOAD) begin
            cnt_nxt    = ld_cnt;
            sorted_nxt = req.last;
            kind_nxt   = stbst_pkg::KIND_SORT;
            found_nxt  = 1'b0;
            pos_nxt    = '0;
            sp_nxt     = '0;
            lo_nxt     = '0;
            hi_nxt     = IDX_W'(ld_cnt - CNT_W'(1));
          end else begin
            piv_nxt  = req.value;
            left_nxt = '0;
            rp1_nxt  = cnt_r;
            kind_nxt = stbst_pkg::KIND_SEARCH;
          end
        end
      end
      stbst_pkg::ST_P_RD_HI: piv_nxt = mem_rdata;
      stbst_pkg::ST_P_WR_LO: begin
        i_nxt  = lo_r;
        st_nxt = lo_r;
      end
      stbst_pkg::ST_P_CMP: begin
        tmp_nxt = mem_rdata;
        if (!cmp_lt) begin
          i_nxt = i_r + IDX_W'(1);
        end else if (st_r == i_r) begin
          i_nxt  = i_r + IDX_W'(1);
          st_nxt = st_p1;
        end
      end
      stbst_pkg::ST_P_SWP_B: begin
        i_nxt  = i_r + IDX_W'(1);
        st_nxt = st_p1;
      end
      stbst_pkg::ST_P_NEXT: begin
        // go left, parking the right one if both; else right; else pop
        if (lft_ok) begin
          hi_nxt = st_m1;
          if (rgt_ok) begin
            sp_nxt = sp_r + CNT_W'(1);
          end
        end else if (rgt_ok) begin
          lo_nxt = st_p1;
        end else if (sp_r != '0) begin
          sp_nxt = sp_r - CNT_W'(1);
        end
      end
      stbst_pkg::ST_P_POP: begin
        lo_nxt = stk_rdata[2*IDX_W-1:IDX_W];
        hi_nxt = stk_rdata[IDX_W-1:0];
      end
      stbst_pkg::ST_Q_PROBE: begin
        i_nxt = mid;
        if (!probe_ok) begin
          found_nxt = 1'b0;
          pos_nxt   = '0;
        end
      end
      stbst_pkg::ST_Q_CMP: begin
        if (cmp_eq) begin
          found_nxt = 1'b1;
          pos_nxt   = {{(POS_W-IDX_W){1'b0}}, i_r} + POS_W'(1);
        end else if (cmp_lt) begin
          left_nxt = CNT_W'(i_r) + CNT_W'(1);
        end else begin
          rp1_nxt = CNT_W'(i_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= stbst_pkg::ST_IDLE;
      cnt_r    <= '0;
      sorted_r <= 1'b0;
      sp_r     <= '0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      sorted_r <= sorted_nxt;
      sp_r     <= sp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    i_r     <= i_nxt;
    st_r    <= st_nxt;
    piv_r   <= piv_nxt;
    tmp_r   <= tmp_nxt;
    left_r  <= left_nxt;
    rp1_r   <= rp1_nxt;
    kind_r  <= kind_nxt;
    found_r <= found_nxt;
    pos_r   <= pos_nxt;
  end

endmodule
